// File: hw/rtl/swcl_pkg.sv
// Shared types, constants and helper functions for the stop-and-wait command link.
// This package has no dependencies. The core, the output queue and the top level use it.
package swcl_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned DevW   = 8;
  localparam int unsigned ActW   = 2;
  localparam int unsigned TickW  = 8;
  localparam int unsigned RetryW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ActW-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ActW-1:0] ACT_RX_WORD = 2'd1;
  localparam logic [ActW-1:0] ACT_TICK    = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_RESP_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_SHORT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_LONG   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT  = 2'd3;

  localparam logic [CmdW-1:0] CMD_TGTPOS   = 4'd0;
  localparam logic [CmdW-1:0] CMD_CURPOS   = 4'd1;
  localparam logic [CmdW-1:0] CMD_MOVING   = 4'd2;
  localparam logic [CmdW-1:0] CMD_SENSOR   = 4'd3;
  localparam logic [CmdW-1:0] CMD_WHEELSPD = 4'd4;
  localparam logic [CmdW-1:0] CMD_SETPOS   = 4'd5;
  localparam logic [CmdW-1:0] CMD_SETSPD   = 4'd6;
  localparam logic [CmdW-1:0] CMD_SETMODE  = 4'd7;
  localparam logic [CmdW-1:0] CMD_SETWHEEL = 4'd8;
  localparam logic [CmdW-1:0] CMD_FIRST_INVALID = 4'd9;

  localparam logic [WordW-1:0] ACK_WORD = 16'h0000;
  localparam logic [RetryW-1:0] RETRY_MAX = 4'hf;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [CmdW-1:0]  command;
    logic [DevW-1:0]  dev_addr;
    logic [WordW-1:0] target_value;
    logic [WordW-1:0] rx_word;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [WordW-1:0]  tx_word;
    logic              status;
    logic [WordW-1:0]  response_value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [TickW-1:0]  resp_timeout;
    logic [TickW-1:0]  quiet_short;
    logic [TickW-1:0]  quiet_long;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  function automatic logic [7:0] type_letter(input logic [CmdW-1:0] cmd);
    logic [7:0] letter;
    begin
      case (cmd)
        CMD_TGTPOS:   letter = 8'h70;
        CMD_CURPOS:   letter = 8'h71;
        CMD_MOVING:   letter = 8'h6d;
        CMD_SENSOR:   letter = 8'h76;
        CMD_WHEELSPD: letter = 8'h73;
        CMD_SETPOS:   letter = 8'h50;
        CMD_SETSPD:   letter = 8'h53;
        CMD_SETMODE:  letter = 8'h4d;
        CMD_SETWHEEL: letter = 8'h57;
        default:      letter = 8'h00;
      endcase
      return letter;
    end
  endfunction

endpackage

// File: hw/rtl/swcl_core.sv
// Protocol state and per-event decision logic of the stop-and-wait command link.
// Depends on swcl_pkg. Produces up to two results for each event it processes.
module swcl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  swcl_pkg::in_item_t item_i,
  input  swcl_pkg::cfg_t    cfg_i,
  output logic [1:0]        res_cnt_o,
  output swcl_pkg::result_t res0_o,
  output swcl_pkg::result_t res1_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_QHDR = 3'd1;
  localparam logic [2:0] PH_QACK = 3'd2;
  localparam logic [2:0] PH_SHDR = 3'd3;
  localparam logic [2:0] PH_SVAL = 3'd4;

  logic [2:0]                      phase_q, phase_d;
  logic [swcl_pkg::CmdW-1:0]       cmd_q, cmd_d;
  logic [swcl_pkg::DevW-1:0]       dev_q, dev_d;
  logic [swcl_pkg::WordW-1:0]      tgt_q, tgt_d;
  logic [swcl_pkg::TickW-1:0]      tick_q, tick_d;
  logic [swcl_pkg::RetryW-1:0]     att_q, att_d;
  logic [swcl_pkg::WordW-1:0]      ans_q, ans_d;

  logic [swcl_pkg::TickW-1:0]      tick_inc;
  logic [swcl_pkg::TickW-1:0]      quiet;
  logic [swcl_pkg::RetryW-1:0]     att_inc;
  logic [swcl_pkg::WordW-1:0]      hdr_held;
  logic [swcl_pkg::WordW-1:0]      hdr_new;
  logic [1:0]                      cnt;
  swcl_pkg::result_t               r0, r1;

  assign hdr_held = {swcl_pkg::type_letter(cmd_q), dev_q};
  assign hdr_new  = {swcl_pkg::type_letter(item_i.command), item_i.dev_addr};
  assign tick_inc = tick_q + 8'd1;
  assign att_inc  = (att_q < swcl_pkg::RETRY_MAX) ? att_q + 4'd1 : att_q;
  assign quiet    = (cmd_q <= swcl_pkg::CMD_MOVING) ? cfg_i.quiet_short : cfg_i.quiet_long;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    dev_d   = dev_q;
    tgt_d   = tgt_q;
    tick_d  = tick_q;
    att_d   = att_q;
    ans_d   = ans_q;
    cnt     = 2'd0;
    r0      = '0;
    r1      = '0;
    case (item_i.action)
      swcl_pkg::ACT_REQUEST: begin
        if (phase_q == PH_IDLE) begin
          cmd_d  = item_i.command;
          dev_d  = item_i.dev_addr;
          tgt_d  = item_i.target_value;
          tick_d = '0;
          att_d  = '0;
          ans_d  = '0;
          cnt    = 2'd1;
          if (item_i.command < swcl_pkg::CMD_SETPOS) begin
            phase_d    = PH_QHDR;
            r0.tx_word = hdr_new;
          end else if (item_i.command < swcl_pkg::CMD_FIRST_INVALID) begin
            phase_d    = PH_SHDR;
            r0.tx_word = hdr_new;
          end else begin
            r0.kind = 1'b1;
          end
        end
      end
      swcl_pkg::ACT_RX_WORD: begin
        case (phase_q)
          PH_QHDR: begin
            ans_d   = item_i.rx_word;
            phase_d = PH_QACK;
            tick_d  = '0;
            cnt     = 2'd1;
            r0.tx_word = swcl_pkg::ACK_WORD;
          end
          PH_QACK: begin
            tick_d = '0;
            cnt    = 2'd1;
            r0.tx_word = swcl_pkg::ACK_WORD;
          end
          PH_SHDR, PH_SVAL: begin
            tick_d = '0;
            if (item_i.rx_word == swcl_pkg::ACK_WORD) begin
              cnt = 2'd1;
              if (phase_q == PH_SHDR) begin
                phase_d    = PH_SVAL;
                r0.tx_word = tgt_q;
              end else begin
                phase_d = PH_IDLE;
                r0.kind = 1'b1;
              end
            end else begin
              cnt        = 2'd2;
              r0.tx_word = swcl_pkg::ACK_WORD;
              r1.tx_word = (phase_q == PH_SHDR) ? hdr_held : tgt_q;
            end
          end
          default: begin
          end
        endcase
      end
      swcl_pkg::ACT_TICK: begin
        if (phase_q != PH_IDLE) begin
          tick_d = tick_inc;
          if (phase_q == PH_QACK) begin
            if (tick_inc >= quiet) begin
              phase_d = PH_IDLE;
              tick_d  = '0;
              cnt     = 2'd1;
              r0.kind = 1'b1;
              r0.response_value = ans_q;
            end
          end else if (tick_inc >= cfg_i.resp_timeout) begin
            tick_d = '0;
            cnt    = 2'd1;
            if (phase_q == PH_QHDR && cmd_q >= swcl_pkg::CMD_MOVING) begin
              att_d = att_inc;
              if (att_inc >= cfg_i.retry_limit) begin
                phase_d   = PH_IDLE;
                r0.kind   = 1'b1;
                r0.status = 1'b1;
              end else begin
                r0.tx_word = hdr_held;
              end
            end else if (phase_q == PH_SVAL) begin
              r0.tx_word = tgt_q;
            end else begin
              r0.tx_word = hdr_held;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      dev_q   <= '0;
      tgt_q   <= '0;
      tick_q  <= '0;
      att_q   <= '0;
      ans_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      dev_q   <= dev_d;
      tgt_q   <= tgt_d;
      tick_q  <= tick_d;
      att_q   <= att_d;
      ans_q   <= ans_d;
    end
  end

  assign res_cnt_o = fire_i ? cnt : 2'd0;
  assign res0_o    = r0;
  assign res1_o    = r1;

endmodule

// File: hw/rtl/swcl_out_fifo.sv
// Result queue of the stop-and-wait command link: takes up to two results per cycle.
// Depends on swcl_pkg. Hands one result per transfer to the output side.
module swcl_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  swcl_pkg::result_t push0_i,
  input  swcl_pkg::result_t push1_i,
  output logic              room2_o,
  output logic              valid_o,
  input  logic              ready_i,
  output swcl_pkg::result_t data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  swcl_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;
  logic [PtrW-1:0] wr_next;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign data_o  = mem_q[rd_q];
  assign wr_next = wr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_cnt_i);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + (PtrW+1)'(push_cnt_i) - (PtrW+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/stop_and_wait_command_link_unit.sv
// Top level of the stop-and-wait command link requester.
// Depends on swcl_pkg, swcl_core and swcl_out_fifo; holds the input register and config.
//
// Channel   Direction  Carries
// s_axis    in         one event: request, received radio word or time tick
// m_axis    out        one result: word to transmit or request finished
// cfg       in         register writes, index 0..3, no read-back
//
// An event is processed from the input register once the queue has room for two results.
// A new event is taken every cycle while the result queue has room for two results.
// An event yields up to two results; one drains per cycle while m_axis_tready is high.
// Reset returns the link to idle and the registers to 20, 30, 50 and 5.
module stop_and_wait_command_link_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[3:0], dev_addr[11:4], target_value[27:12], rx_word[43:28], zero fill
  input  logic [47:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_word[15:0], status[16], response_value[32:17], zero fill
  output logic [39:0] m_axis_tdata,
  // kind[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [swcl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swcl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  swcl_pkg::in_item_t item_q;
  logic               item_vld_q;
  logic               advance;
  logic               room2;
  swcl_pkg::cfg_t     cfg_q;
  logic [1:0]         res_cnt;
  swcl_pkg::result_t  res0, res1, head;

  assign advance       = item_vld_q && room2;
  assign s_axis_tready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.action       <= s_axis_tuser;
      item_q.command      <= s_axis_tdata[3:0];
      item_q.dev_addr     <= s_axis_tdata[11:4];
      item_q.target_value <= s_axis_tdata[27:12];
      item_q.rx_word      <= s_axis_tdata[43:28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp_timeout <= 8'd20;
      cfg_q.quiet_short  <= 8'd30;
      cfg_q.quiet_long   <= 8'd50;
      cfg_q.retry_limit  <= 4'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swcl_pkg::CFG_RESP_TIMEOUT: cfg_q.resp_timeout <= cfg_wdata_i;
        swcl_pkg::CFG_QUIET_SHORT:  cfg_q.quiet_short  <= cfg_wdata_i;
        swcl_pkg::CFG_QUIET_LONG:   cfg_q.quiet_long   <= cfg_wdata_i;
        swcl_pkg::CFG_RETRY_LIMIT:  cfg_q.retry_limit  <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  swcl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  swcl_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (head)
  );

  assign m_axis_tdata = {7'd0, head.response_value, head.status, head.tx_word};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// File: tb/stop_and_wait_command_link_unit_test.sv
// Self-checking testbench for stop_and_wait_command_link_unit.
// Drives request, radio word and tick events, predicts every transmit word and finish result.
// Depends on swcl_pkg and the RTL of the unit only.
`timescale 1ns / 100ps

module stop_and_wait_command_link_unit_test;
  import swcl_pkg::*;

  localparam logic [ActW-1:0] ACT_UNUSED    = 2'd3;
  localparam logic [CmdW-1:0] CMD_LAST_CODE = 4'd15;
  localparam int unsigned     CYCLE_LIMIT   = 400000;
  localparam int unsigned     DRAIN_CYCLES  = 16;

  typedef enum logic [2:0] {
    LINK_IDLE, LINK_QUERY_HDR, LINK_QUERY_ACK, LINK_SET_HDR, LINK_SET_VALUE
  } link_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_wdata_i = '0;

  stop_and_wait_command_link_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0] cfg_timeout = 8'd20;
  logic [7:0] cfg_quiet_short = 8'd30;
  logic [7:0] cfg_quiet_long = 8'd50;
  logic [3:0] cfg_retry = 4'd5;

  link_phase_e link_phase = LINK_IDLE;
  logic [3:0]  held_cmd = '0;
  logic [7:0]  held_dev = '0;
  logic [15:0] held_tgt = '0;
  logic [7:0]  tick_cnt = '0;
  logic [3:0]  attempt_cnt = '0;
  logic [15:0] answer_word = '0;

  logic [7:0] letter_tab [0:8] = '{8'h70, 8'h71, 8'h6d, 8'h76, 8'h73, 8'h50, 8'h53, 8'h4d, 8'h57};

  in_item_t pending_events [$];
  result_t  awaited_out [$];
  int       offered = 0;
  int       fault_count = 0;
  int       results_seen = 0;
  int       hold_on_result = -1;
  int unsigned cycle_count = 0;

  function automatic logic [15:0] header_word_now();
    return {(held_cmd < CMD_FIRST_INVALID) ? letter_tab[held_cmd] : 8'h00, held_dev};
  endfunction

  function automatic void emit(logic k, logic [15:0] tx, logic st, logic [15:0] resp);
    result_t r;
    r.kind = k;
    r.tx_word = tx;
    r.status = st;
    r.response_value = resp;
    r.last = 1'b0;
    awaited_out.push_back(r);
  endfunction

  function automatic void advance_link(in_item_t ev);
    int unsigned before_n;
    logic [7:0]  quiet;
    before_n = awaited_out.size();
    case (ev.action)
      ACT_REQUEST: begin
        if (link_phase == LINK_IDLE) begin
          held_cmd = ev.command;
          held_dev = ev.dev_addr;
          held_tgt = ev.target_value;
          tick_cnt = '0;
          attempt_cnt = '0;
          answer_word = '0;
          if (held_cmd < CMD_SETPOS) begin
            link_phase = LINK_QUERY_HDR;
            emit(1'b0, header_word_now(), 1'b0, '0);
          end else if (held_cmd < CMD_FIRST_INVALID) begin
            link_phase = LINK_SET_HDR;
            emit(1'b0, header_word_now(), 1'b0, '0);
          end else begin
            emit(1'b1, '0, 1'b0, '0);
          end
        end
      end
      ACT_RX_WORD: begin
        case (link_phase)
          LINK_QUERY_HDR: begin
            answer_word = ev.rx_word;
            link_phase = LINK_QUERY_ACK;
            tick_cnt = '0;
            emit(1'b0, ACK_WORD, 1'b0, '0);
          end
          LINK_QUERY_ACK: begin
            tick_cnt = '0;
            emit(1'b0, ACK_WORD, 1'b0, '0);
          end
          LINK_SET_HDR, LINK_SET_VALUE: begin
            tick_cnt = '0;
            if (ev.rx_word == ACK_WORD) begin
              if (link_phase == LINK_SET_HDR) begin
                link_phase = LINK_SET_VALUE;
                emit(1'b0, held_tgt, 1'b0, '0);
              end else begin
                link_phase = LINK_IDLE;
                emit(1'b1, '0, 1'b0, '0);
              end
            end else begin
              emit(1'b0, ACK_WORD, 1'b0, '0);
              emit(1'b0, (link_phase == LINK_SET_HDR) ? header_word_now() : held_tgt, 1'b0, '0);
            end
          end
          default: begin
          end
        endcase
      end
      ACT_TICK: begin
        if (link_phase != LINK_IDLE) begin
          tick_cnt = tick_cnt + 8'd1;
          if (link_phase == LINK_QUERY_ACK) begin
            quiet = (held_cmd <= CMD_MOVING) ? cfg_quiet_short : cfg_quiet_long;
            if (tick_cnt >= quiet) begin
              link_phase = LINK_IDLE;
              tick_cnt = '0;
              emit(1'b1, '0, 1'b0, answer_word);
            end
          end else if (tick_cnt >= cfg_timeout) begin
            tick_cnt = '0;
            if (link_phase == LINK_QUERY_HDR && held_cmd >= CMD_MOVING) begin
              if (attempt_cnt < RETRY_MAX) attempt_cnt = attempt_cnt + 4'd1;
              if (attempt_cnt >= cfg_retry) begin
                link_phase = LINK_IDLE;
                emit(1'b1, '0, 1'b1, '0);
              end else begin
                emit(1'b0, header_word_now(), 1'b0, '0);
              end
            end else if (link_phase == LINK_SET_VALUE) begin
              emit(1'b0, held_tgt, 1'b0, '0);
            end else begin
              emit(1'b0, header_word_now(), 1'b0, '0);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (awaited_out.size() > before_n) awaited_out[awaited_out.size() - 1].last = 1'b1;
  endfunction

  // Sender: bursts of transfers separated by random gaps.
  in_item_t in_flight;
  int       burst_left = 1;
  int       gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) advance_link(in_flight);
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        in_flight = pending_events.pop_front();
        s_axis_tdata <= {4'b0, in_flight.rx_word, in_flight.target_value,
                         in_flight.dev_addr, in_flight.command};
        s_axis_tuser <= in_flight.action;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transfer; stalls on a rotating pattern and one long hold.
  logic [15:0] ready_pattern = 16'hffff;
  int          pattern_age = 0;
  int          hold_left = 0;

  always @(posedge clk_i) begin : out_check
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.tx_word = m_axis_tdata[15:0];
        got.status = m_axis_tdata[16];
        got.response_value = m_axis_tdata[32:17];
        got.last = m_axis_tlast;
        results_seen++;
        if (results_seen == hold_on_result) hold_left = 150;
        if (awaited_out.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected result: kind %0d tx %h status %0d resp %h last %0d",
                     got.kind, got.tx_word, got.status, got.response_value, got.last);
          fault_count++;
        end else begin
          want = awaited_out.pop_front();
          if (got !== want) begin
            if (fault_count < 10) begin
              $write("result %0d mismatch (expected/actual): kind %0d/%0d tx %h/%h ",
                     results_seen, want.kind, got.kind, want.tx_word, got.tx_word);
              $display("status %0d/%0d resp %h/%h last %0d/%0d",
                       want.status, got.status, want.response_value, got.response_value,
                       want.last, got.last);
            end
            fault_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ready_pattern[0];
        if (pattern_age == 63) begin
          pattern_age = 0;
          ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                          : (16'($urandom) | 16'h8001);
        end else begin
          pattern_age++;
          ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic offer(input logic [1:0] act, input logic [3:0] cmd, input logic [7:0] dev,
                       input logic [15:0] tgt, input logic [15:0] rx);
    in_item_t it;
    it.action = act;
    it.command = cmd;
    it.dev_addr = dev;
    it.target_value = tgt;
    it.rx_word = rx;
    pending_events.push_back(it);
    offered++;
  endtask

  task automatic offer_word(input logic [15:0] rx);
    offer(ACT_RX_WORD, 4'($urandom), 8'($urandom), 16'($urandom), rx);
  endtask

  task automatic offer_ticks(input int n);
    repeat (n) offer(ACT_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_RESP_TIMEOUT: cfg_timeout = val;
      CFG_QUIET_SHORT:  cfg_quiet_short = val;
      CFG_QUIET_LONG:   cfg_quiet_long = val;
      default:          cfg_retry = val[3:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_regs(input logic [7:0] tmo, input logic [7:0] qs,
                              input logic [7:0] ql, input logic [7:0] retry);
    write_reg(CFG_RESP_TIMEOUT, tmo);
    write_reg(CFG_QUIET_SHORT, qs);
    write_reg(CFG_QUIET_LONG, ql);
    write_reg(CFG_RETRY_LIMIT, retry);
  endtask

  // One request with a plausible conversation around it, or a single stray event.
  task automatic queue_exchange();
    logic [3:0] cmd;
    int tmo;
    int quiet;
    int retries;
    int roll;
    tmo = (cfg_timeout == 0) ? 1 : int'(cfg_timeout);
    retries = (cfg_retry == 0) ? 1 : int'(cfg_retry);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      offer(2'($urandom), 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      cmd = (roll < 14) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      offer(ACT_REQUEST, cmd, 8'($urandom), 16'($urandom), 16'($urandom));
      if (cmd < CMD_SETPOS) begin
        quiet = int'((cmd <= CMD_MOVING) ? cfg_quiet_short : cfg_quiet_long);
        if (quiet == 0) quiet = 1;
        if (cmd >= CMD_MOVING && $urandom_range(0, 5) == 0 && tmo * retries <= 300) begin
          offer_ticks(tmo * retries);
        end else begin
          repeat ($urandom_range(0, (tmo > 32) ? 1 : 2)) offer_ticks(tmo);
          offer_ticks($urandom_range(0, tmo - 1));
          if ($urandom_range(0, 7) == 0)
            offer(ACT_REQUEST, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
          offer_word(($urandom_range(0, 3) == 0) ? ACK_WORD : 16'($urandom));
          repeat ($urandom_range(0, 2)) begin
            offer_ticks($urandom_range(0, quiet - 1));
            offer_word(16'($urandom));
          end
          offer_ticks(quiet + $urandom_range(0, 1));
        end
      end else if (cmd < CMD_FIRST_INVALID) begin
        repeat (2) begin
          repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) == 0) offer_word(16'($urandom_range(1, 65535)));
            else offer_ticks(tmo);
          end
          offer_ticks($urandom_range(0, tmo - 1));
          offer_word(ACK_WORD);
        end
      end
    end
  endtask

  task automatic settle();
    while (pending_events.size() != 0 || s_axis_tvalid || awaited_out.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_traffic(input int n);
    int goal;
    goal = offered + n;
    while (offered < goal) queue_exchange();
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_traffic(200);

    program_regs(8'd2, 8'd3, 8'd4, 8'd3);
    offer_ticks(1);
    offer_word(16'hffff);
    offer(ACT_UNUSED, CMD_LAST_CODE, 8'hff, 16'hffff, 16'hffff);
    offer(ACT_REQUEST, CMD_LAST_CODE, 8'hff, 16'h7fff, ACK_WORD);
    offer(ACT_REQUEST, CMD_FIRST_INVALID, 8'h00, 16'h8000, ACK_WORD);
    offer(ACT_REQUEST, CMD_TGTPOS, 8'hff, 16'h0000, ACK_WORD);
    offer(ACT_REQUEST, CMD_SETPOS, 8'h12, 16'h1234, ACK_WORD);
    offer_ticks(2);
    offer_word(ACK_WORD);
    offer_word(16'hffff);
    offer_ticks(3);
    offer(ACT_REQUEST, CMD_SENSOR, 8'h5a, 16'h0000, ACK_WORD);
    offer_ticks(6);
    offer(ACT_REQUEST, CMD_SETPOS, 8'h01, 16'h8000, ACK_WORD);
    offer_word(16'h00ff);
    offer_word(ACK_WORD);
    offer_word(ACK_WORD);
    settle();

    program_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
    hold_on_result = results_seen + 40;
    run_traffic(300);

    program_regs(8'd255, 8'd255, 8'd255, 8'd15);
    run_traffic(450);

    program_regs(8'd0, 8'd0, 8'd0, 8'd0);
    run_traffic(120);

    program_regs(8'd1, 8'd1, 8'd1, 8'd1);
    run_traffic(80);

    program_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
    run_traffic(100);

    if (fault_count == 0 && awaited_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/swcl_pkg.sv
hw/rtl/swcl_core.sv
hw/rtl/swcl_out_fifo.sv
hw/rtl/stop_and_wait_command_link_unit.sv
tb/stop_and_wait_command_link_unit_test.sv
